// ===== rtl/grwd_pkg.sv =====
// grwd_pkg: shared constants, job and handshake structs for the grid ray caster
// no dependencies; imported by every other file of the block

package grwd_pkg;

  // default parameter values
  localparam int GRID_SIDE_DEF = 16;
  localparam int MAX_STEPS_DEF = 32;

  // field widths
  localparam int COORD_W = 24;
  localparam int DELTA_W = COORD_W + 1;
  localparam int FRAC_W  = 16;
  localparam int STEP_W  = 6;
  localparam int DIST_W  = 24;
  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 6'd10;
  localparam int FX_ONE  = 1 << FRAC_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // divider: numerator magnitude and divisor widths
  localparam int NUM_W = 40;
  localparam int DEN_W = 24;

  // square root operand width (even) and root width
  localparam int SQ_W   = 52;
  localparam int ROOT_W = SQ_W / 2;

  // job queue depth
  localparam int JOB_Q_DEPTH = 2;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  // one queued job as classified by the front part
  typedef struct packed {
    logic                      kind;
    logic [3:0]                cell_col;
    logic [3:0]                cell_row;
    logic                      cell_is_wall;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic                      skip_v;
    logic                      skip_h;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_out_t;

  typedef struct packed {
    logic job_ready;
    logic clear_done;
  } back_sts_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W:0]   num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W:0]   quo;
    logic [DEN_W-1:0]        rem;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== rtl/grwd_if.sv =====
// grwd_if: valid/ready channel interfaces for items, results and configuration
// depends on grwd_pkg for field widths

interface grwd_item_if import grwd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [3:0]                cell_col;
  logic [3:0]                cell_row;
  logic                      cell_is_wall;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] toward_x;
  logic signed [COORD_W-1:0] toward_y;

  modport source (output valid, kind, cell_col, cell_row, cell_is_wall,
                  origin_x, origin_y, toward_x, toward_y, input ready);
  modport sink (input valid, kind, cell_col, cell_row, cell_is_wall,
                origin_x, origin_y, toward_x, toward_y, output ready);
endinterface

interface grwd_result_if import grwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] wall_distance;

  modport source (output valid, hit, wall_distance, input ready);
  modport sink (input valid, hit, wall_distance, output ready);
endinterface

interface grwd_cfg_if import grwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_limit;

  modport source (output valid, step_limit, input ready);
  modport sink (input valid, step_limit, output ready);
endinterface

// ===== rtl/grwd_div.sv =====
// grwd_div: iterative floor divider, signed numerator by positive divisor
// one quotient bit per cycle; depends on grwd_pkg

module grwd_div import grwd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIX} dv_state_e;
  localparam int CNT_W = $clog2(NUM_W + 1);

  dv_state_e             state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  neg_q;
  logic [DEN_W-1:0]      den_q;
  logic [DEN_W-1:0]      rem_q;
  logic [NUM_W-1:0]      work_q;
  logic                  done_q;
  logic signed [NUM_W:0] quo_q;
  logic [DEN_W-1:0]      rout_q;

  logic [DEN_W:0]        rem_t;
  logic [DEN_W:0]        rem_sub;
  logic                  ge;
  logic signed [NUM_W:0] num_neg;
  logic [NUM_W-1:0]      mag;
  logic                  rem_nz;
  logic signed [NUM_W:0] qpos;
  logic signed [NUM_W:0] qfix;
  logic [DEN_W-1:0]      rfix;

  // restoring step
  assign rem_t   = {rem_q, work_q[NUM_W-1]};
  assign rem_sub = rem_t - {1'b0, den_q};
  assign ge      = (rem_t >= {1'b0, den_q});

  // magnitude of the incoming numerator
  assign num_neg = -req_i.num;
  assign mag     = req_i.num[NUM_W] ? num_neg[NUM_W-1:0] : req_i.num[NUM_W-1:0];

  // round toward minus infinity for negative numerators
  assign rem_nz = |rem_q;
  assign qpos   = $signed({1'b0, work_q});
  assign qfix   = neg_q ? (-qpos - $signed((NUM_W + 1)'(rem_nz))) : qpos;
  assign rfix   = (neg_q && rem_nz) ? (den_q - rem_q) : rem_q;

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rout_q;

  // divider sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DV_IDLE: begin
          if (req_i.start) begin
            neg_q   <= req_i.num[NUM_W];
            den_q   <= req_i.den;
            rem_q   <= '0;
            work_q  <= mag;
            cnt_q   <= '0;
            state_q <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem_q  <= ge ? rem_sub[DEN_W-1:0] : rem_t[DEN_W-1:0];
          work_q <= {work_q[NUM_W-2:0], ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(NUM_W - 1)) begin
            state_q <= DV_FIX;
          end
        end
        DV_FIX: begin
          quo_q   <= qfix;
          rout_q  <= rfix;
          done_q  <= 1'b1;
          state_q <= DV_IDLE;
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/grwd_sqrt.sv =====
// grwd_sqrt: iterative integer square root, one root bit per cycle
// depends on grwd_pkg

module grwd_sqrt import grwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  typedef enum logic {SQ_IDLE, SQ_RUN} sq_state_e;
  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int RW    = ROOT_W + 3;

  sq_state_e         state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RW-3:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SQ_W-1:0]   work_q;
  logic              done_q;

  logic [RW-1:0]     rem_t;
  logic [RW-1:0]     trial;
  logic [RW-1:0]     rem_sub;
  logic              ge;

  // trial subtract of 4*root+1
  assign rem_t   = {rem_q, work_q[SQ_W-1:SQ_W-2]};
  assign trial   = RW'({root_q, 2'b01});
  assign rem_sub = rem_t - trial;
  assign ge      = (rem_t >= trial);

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

  // root sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SQ_IDLE: begin
          if (req_i.start) begin
            rem_q   <= '0;
            root_q  <= '0;
            work_q  <= req_i.radicand;
            cnt_q   <= '0;
            state_q <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          rem_q  <= ge ? rem_sub[RW-3:0] : rem_t[RW-3:0];
          root_q <= {root_q[ROOT_W-2:0], ge};
          work_q <= {work_q[SQ_W-3:0], 2'b00};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ROOT_W - 1)) begin
            done_q  <= 1'b1;
            state_q <= SQ_IDLE;
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/grwd_front.sv =====
// grwd_front: accepts item beats, forms ray deltas and queues jobs
// depends on grwd_pkg and grwd_item_if

module grwd_front import grwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  grwd_item_if.sink item_i,
  output job_out_t  job_o,
  input  back_sts_t sts_i
);

  localparam int PTR_W = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

  job_t             fifo_q [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [CNT_W-1:0] cnt_q;

  logic push;
  logic pop;
  job_t entry;

  // classify the beat into a job
  always_comb begin
    entry.kind         = item_i.kind;
    entry.cell_col     = item_i.cell_col;
    entry.cell_row     = item_i.cell_row;
    entry.cell_is_wall = item_i.cell_is_wall;
    entry.origin_x     = item_i.origin_x;
    entry.origin_y     = item_i.origin_y;
    entry.delta_x      = DELTA_W'(item_i.toward_x) - DELTA_W'(item_i.origin_x);
    entry.delta_y      = DELTA_W'(item_i.toward_y) - DELTA_W'(item_i.origin_y);
    entry.skip_v       = (entry.delta_x == '0);
    entry.skip_h       = (entry.delta_y == '0);
  end

  assign item_i.ready = (cnt_q != CNT_W'(JOB_Q_DEPTH)) && sts_i.clear_done;
  assign push         = item_i.valid && item_i.ready;
  assign job_o.valid  = (cnt_q != '0);
  assign job_o.job    = fifo_q[rptr_q];
  assign pop          = job_o.valid && sts_i.job_ready;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= entry;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/grwd_back.sv =====
// grwd_back: wall map, crossing march, distance and result register
// depends on grwd_pkg, grwd_result_if, grwd_div and grwd_sqrt

module grwd_back import grwd_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_out_t          job_i,
  output back_sts_t         sts_o,
  input  logic [STEP_W-1:0] step_n_i,
  grwd_result_if.source     result_o
);

  localparam int CW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int QW    = 48;
  localparam int PW    = 11;
  localparam int EW    = FRAC_W + STEP_W;
  localparam int QMW   = 25;

  typedef enum logic [3:0] {
    BK_CLEAR, BK_IDLE, BK_FAM, BK_MUL, BK_WAIT0, BK_SLOPE, BK_WAITS,
    BK_RD, BK_TEST, BK_SQ, BK_SUM, BK_ROOT, BK_RWAIT, BK_NEXT, BK_DONE
  } bk_state_e;

  bk_state_e state_q;
  logic [AW-1:0] clr_addr_q;
  job_t job_q;
  logic fam_h_q;

  logic                  pos_q;
  logic [DEN_W-1:0]      den_q;
  logic signed [PW-1:0]  pidx_q;
  logic [EW-1:0]         emag_q;
  logic signed [COORD_W-1:0] oac_q;
  logic signed [DELTA_W-1:0] dac_q;
  logic signed [NUM_W:0] num_q;
  logic signed [QW-1:0]  q_q;
  logic [DEN_W-1:0]      r_q;
  logic signed [NUM_W:0] qs_q;
  logic [DEN_W-1:0]      rs_q;
  logic [STEP_W-1:0]     i_q;
  logic                  ingrid_q;
  logic [2*EW-1:0]       sqa_q;
  logic [2*QMW-1:0]      sqb_q;
  logic [SQ_W-1:0]       rad_q;
  logic                  hit_q;
  logic [DIST_W-1:0]     best_q;
  logic                  res_valid_q;
  logic                  res_hit_q;
  logic [DIST_W-1:0]     res_dist_q;

  logic mem_q [DEPTH];
  logic rd_q;

  // family selection
  logic signed [COORD_W-1:0] o_al;
  logic signed [COORD_W-1:0] o_ac;
  logic signed [DELTA_W-1:0] d_al;
  logic signed [DELTA_W-1:0] d_ac;
  logic                      skip;
  logic [FRAC_W-1:0]         frac;
  logic                      pos_f;
  logic [FRAC_W-1:0]         e0mag;
  logic signed [DELTA_W-1:0] d_al_neg;
  logic [DEN_W-1:0]          d_al_abs;
  logic signed [NUM_W+1:0]   prod;
  logic signed [PW-1:0]      pidx0;

  // crossing address
  logic signed [PW-1:0] al_cell;
  logic signed [QW-1:0] a_sum;
  logic                 al_ok;
  logic                 ac_ok;
  logic [CW-1:0]        ac_cell;
  logic [AW-1:0]        rd_addr;

  // advance
  logic [DEN_W:0]       rsum;
  logic                 carry;
  logic [DEN_W-1:0]     r_next;
  logic signed [QW-1:0] q_next;

  // distance
  logic signed [QW-1:0] q_neg;
  logic [QMW-1:0]       qmag;
  logic [DIST_W-1:0]    dist_sat;

  // map write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic          wr_in_range;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  grwd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  grwd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  // pick axes of the current crossing family
  always_comb begin
    o_al     = fam_h_q ? job_q.origin_y : job_q.origin_x;
    o_ac     = fam_h_q ? job_q.origin_x : job_q.origin_y;
    d_al     = fam_h_q ? job_q.delta_y : job_q.delta_x;
    d_ac     = fam_h_q ? job_q.delta_x : job_q.delta_y;
    skip     = fam_h_q ? job_q.skip_h : job_q.skip_v;
    frac     = o_al[FRAC_W-1:0];
    pos_f    = !d_al[DELTA_W-1];
    e0mag    = pos_f ? (-frac) : frac;
    d_al_neg = -d_al;
    d_al_abs = d_al[DELTA_W-1] ? d_al_neg[DEN_W-1:0] : d_al[DEN_W-1:0];
    prod     = $signed({1'b0, e0mag}) * d_ac;
    pidx0    = PW'($signed(o_al[COORD_W-1:FRAC_W]))
             + $signed(PW'(pos_f && (frac != '0)));
  end

  // cell hit by the current crossing
  always_comb begin
    al_cell = pidx_q - $signed(PW'(!pos_q));
    a_sum   = QW'(oac_q) + q_q;
    al_ok   = !al_cell[PW-1] && (al_cell < PW'(GRID_SIDE));
    ac_ok   = !a_sum[QW-1] && (a_sum[QW-1:FRAC_W] < (QW - FRAC_W)'(GRID_SIDE));
    ac_cell = a_sum[FRAC_W +: CW];
    rd_addr = fam_h_q ? {al_cell[CW-1:0], ac_cell} : {ac_cell, al_cell[CW-1:0]};
  end

  // step to the next crossing with remainder carry
  always_comb begin
    rsum   = {1'b0, r_q} + {1'b0, rs_q};
    carry  = (rsum >= {1'b0, den_q});
    r_next = carry ? DEN_W'(rsum - {1'b0, den_q}) : rsum[DEN_W-1:0];
    q_next = q_q + QW'(qs_q) + $signed(QW'(carry));
  end

  // distance operands and saturation
  assign q_neg    = -q_q;
  assign qmag     = q_q[QW-1] ? q_neg[QMW-1:0] : q_q[QMW-1:0];
  assign dist_sat = (sq_rsp.root[ROOT_W-1:DIST_W] != '0) ? DIST_MAX
                                                          : sq_rsp.root[DIST_W-1:0];

  // unit requests
  assign div_req.start   = (state_q == BK_MUL) || (state_q == BK_SLOPE);
  assign div_req.num     = num_q;
  assign div_req.den     = den_q;
  assign sq_req.start    = (state_q == BK_ROOT);
  assign sq_req.radicand = rad_q;

  assign sts_o.job_ready  = (state_q == BK_IDLE);
  assign sts_o.clear_done = (state_q != BK_CLEAR);

  assign result_o.valid         = res_valid_q;
  assign result_o.hit           = res_hit_q;
  assign result_o.wall_distance = res_dist_q;

  // map write: clearing pass or write job
  assign wr_in_range = (32'(job_i.job.cell_col) < GRID_SIDE)
                    && (32'(job_i.job.cell_row) < GRID_SIDE);
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_q;
    wr_data = 1'b0;
    if (state_q == BK_CLEAR) begin
      wr_en = 1'b1;
    end else if (state_q == BK_IDLE && job_i.valid && job_i.job.kind == KIND_WRITE
                 && wr_in_range) begin
      wr_en   = 1'b1;
      wr_addr = {CW'(job_i.job.cell_row), CW'(job_i.job.cell_col)};
      wr_data = job_i.job.cell_is_wall;
    end
  end

  // wall map
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // job sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      fam_h_q     <= 1'b0;
    end else begin
      if (res_valid_q && result_o.ready && state_q != BK_DONE) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        BK_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            state_q <= BK_IDLE;
          end
        end
        BK_IDLE: begin
          if (job_i.valid && job_i.job.kind == KIND_CAST) begin
            job_q   <= job_i.job;
            hit_q   <= 1'b0;
            best_q  <= '0;
            fam_h_q <= 1'b0;
            state_q <= BK_FAM;
          end
        end
        BK_FAM: begin
          if (skip) begin
            state_q <= BK_NEXT;
          end else begin
            pos_q   <= pos_f;
            den_q   <= d_al_abs;
            pidx_q  <= pidx0;
            emag_q  <= EW'(e0mag);
            oac_q   <= o_ac;
            dac_q   <= d_ac;
            num_q   <= prod[NUM_W:0];
            state_q <= BK_MUL;
          end
        end
        BK_MUL: begin
          state_q <= BK_WAIT0;
        end
        BK_WAIT0: begin
          if (div_rsp.done) begin
            q_q     <= QW'(div_rsp.quo);
            r_q     <= div_rsp.rem;
            num_q   <= $signed({dac_q, {FRAC_W{1'b0}}});
            state_q <= BK_SLOPE;
          end
        end
        BK_SLOPE: begin
          state_q <= BK_WAITS;
        end
        BK_WAITS: begin
          if (div_rsp.done) begin
            qs_q    <= div_rsp.quo;
            rs_q    <= div_rsp.rem;
            i_q     <= '0;
            state_q <= BK_RD;
          end
        end
        BK_RD: begin
          if (i_q == step_n_i) begin
            state_q <= BK_NEXT;
          end else begin
            ingrid_q <= al_ok && ac_ok;
            state_q  <= BK_TEST;
          end
        end
        BK_TEST: begin
          if (ingrid_q && rd_q) begin
            state_q <= BK_SQ;
          end else begin
            q_q     <= q_next;
            r_q     <= r_next;
            pidx_q  <= pos_q ? (pidx_q + 1'b1) : (pidx_q - 1'b1);
            emag_q  <= emag_q + EW'(FX_ONE);
            i_q     <= i_q + 1'b1;
            state_q <= BK_RD;
          end
        end
        BK_SQ: begin
          sqa_q   <= emag_q * emag_q;
          sqb_q   <= qmag * qmag;
          state_q <= BK_SUM;
        end
        BK_SUM: begin
          rad_q   <= SQ_W'(sqa_q) + SQ_W'(sqb_q);
          state_q <= BK_ROOT;
        end
        BK_ROOT: begin
          state_q <= BK_RWAIT;
        end
        BK_RWAIT: begin
          if (sq_rsp.done) begin
            if (!hit_q || dist_sat < best_q) begin
              best_q <= dist_sat;
            end
            hit_q   <= 1'b1;
            state_q <= BK_NEXT;
          end
        end
        BK_NEXT: begin
          if (!fam_h_q) begin
            fam_h_q <= 1'b1;
            state_q <= BK_FAM;
          end else begin
            state_q <= BK_DONE;
          end
        end
        BK_DONE: begin
          if (!res_valid_q || result_o.ready) begin
            res_valid_q <= 1'b1;
            res_hit_q   <= hit_q;
            res_dist_q  <= hit_q ? best_q : '0;
            state_q     <= BK_IDLE;
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_hit_q) |-> (res_dist_q == '0))
    else $error("no-hit result carries a distance");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == BK_WAIT0 || state_q == BK_WAITS))
    else $error("divider finished outside a wait state");
  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_rsp.done |-> (state_q == BK_RWAIT))
    else $error("root finished outside its wait state");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_TEST) |-> (i_q < step_n_i))
    else $error("crossing examined beyond the step limit");
`endif

endmodule

// ===== rtl/grid_ray_wall_distance_core.sv =====
// grid_ray_wall_distance_core: a write beat is applied to the wall map by the back end; a cast,
// from acceptance to its result beat, handles its two crossing families in turn: a skipped
// family does no division, else two serial divisions run, then the crossings examined are
// walked and a wall hit adds a square root. Casts are handled one at a time. A two-entry job
// queue and the result register keep the input side accepting. After reset the map is
// cleared with the input not ready; step_limit is 10.

module grid_ray_wall_distance_core import grwd_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  grwd_item_if.sink     item_i,
  grwd_result_if.source result_o,
  grwd_cfg_if.sink      cfg_i
);

  logic [STEP_W-1:0] step_limit_q;
  logic [STEP_W-1:0] step_n;
  job_out_t          job;
  back_sts_t         sts;

  // configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q <= STEP_LIMIT_RST;
    end else if (cfg_i.valid) begin
      step_limit_q <= cfg_i.step_limit;
    end
  end

  // crossings per family, clamped
  assign step_n = (32'(step_limit_q) > MAX_STEPS) ? STEP_W'(MAX_STEPS) : step_limit_q;

  grwd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .job_o  (job),
    .sts_i  (sts)
  );

  grwd_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job),
    .sts_o    (sts),
    .step_n_i (step_n),
    .result_o (result_o)
  );

endmodule
